// ===== hdl/pct_pkg.sv =====
`default_nettype none
package pct_pkg;

	localparam int NORM_W = 16;
	localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;

	// Direction vector magnitudes are brought below 2^30 before squaring.
	localparam int MAG_W = 30;
	localparam int SQ_W = 2 * MAG_W + 1;
	localparam int T_W = 62;
	localparam int SHIFT_W = 5;

	localparam int ROOT_W = 31;
	localparam int SREM_W = 33;
	localparam int SQRT_ST = (ROOT_W + 1) / 2;

	localparam int QUOT_W = 16;
	localparam int DREM_W = ROOT_W + 1;
	localparam int DVD_W = ROOT_W + QUOT_W;
	localparam int DIV_ST = QUOT_W / 2 + 1;

	localparam int FRONT_ST = 3;
	localparam int NORM_ST = 2;

	typedef struct packed {
		logic hit;
		logic is_box;
		logic vzero;
		logic sgn_x;
		logic sgn_y;
		logic box_on_x;
		logic box_neg;
	} pct_ctl_t;

	typedef struct packed {
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} pct_sqrt_t;

	typedef struct packed {
		logic q;
		logic [DREM_W-1:0] rem;
	} pct_div_t;

	function automatic pct_sqrt_t sqrt_step(pct_sqrt_t st, logic [1:0] pair);
		logic [SREM_W+1:0] acc;
		logic [SREM_W+1:0] trial;
		pct_sqrt_t r;
		acc = {st.rem, pair};
		trial = {2'b00, st.root, 2'b01};
		if (acc >= trial) begin
			r.rem = SREM_W'(acc - trial);
			r.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = SREM_W'(acc);
			r.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic pct_div_t div_step(logic [DREM_W-1:0] rem, logic din,
			logic [DREM_W-1:0] dvs);
		logic [DREM_W:0] acc;
		pct_div_t r;
		acc = {rem, din};
		if (acc >= {1'b0, dvs}) begin
			r.q = 1'b1;
			r.rem = DREM_W'(acc - {1'b0, dvs});
		end else begin
			r.q = 1'b0;
			r.rem = DREM_W'(acc);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pct_if.sv =====
`default_nettype none
interface pct_pair_if #(parameter int COORD_BITS = 24);
	logic valid;
	logic ready;
	logic a_is_circle;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic [COORD_BITS-2:0] a_size_x;
	logic [COORD_BITS-2:0] a_size_y;
	logic b_is_circle;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic [COORD_BITS-2:0] b_size_x;
	logic [COORD_BITS-2:0] b_size_y;

	modport source (output valid, a_is_circle, a_x, a_y, a_size_x, a_size_y,
		b_is_circle, b_x, b_y, b_size_x, b_size_y, input ready);
	modport sink (input valid, a_is_circle, a_x, a_y, a_size_x, a_size_y,
		b_is_circle, b_x, b_y, b_size_x, b_size_y, output ready);
endinterface

interface pct_result_if import pct_pkg::*; #(parameter int COORD_BITS = 24);
	logic valid;
	logic ready;
	logic colliding;
	logic signed [NORM_W-1:0] normal_x;
	logic signed [NORM_W-1:0] normal_y;
	logic [COORD_BITS-2:0] depth;
	logic signed [COORD_BITS-1:0] contact_x;
	logic signed [COORD_BITS-1:0] contact_y;

	modport source (output valid, colliding, normal_x, normal_y, depth, contact_x,
		contact_y, input ready);
	modport sink (input valid, colliding, normal_x, normal_y, depth, contact_x,
		contact_y, output ready);
endinterface
`default_nettype wire

// ===== hdl/pair_collision_tester.sv =====
// Narrow-phase collision test for one pair of 2D shapes (box or circle each).
// Requests arrive on the pair channel (valid/ready, accepted when both are
// high) and one result leaves on the result channel for every request, in
// order. The block takes a new request in every cycle while the result
// channel does not stall it. Most of the pipeline is the square root of
// the normal's length (16 stages of up to two root bits) and the rounding
// divide that follows (9 stages: a load, then two quotient bits per
// stage).
// Every stage holds a valid bit; a stage advances when it is empty or the
// stage after it advances, so a stall on the result channel fills bubbles
// first and only then drops pair.ready. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// A non-colliding result has zero normal, depth and contact point. Box pairs
// report depth and an axis-aligned normal; other pairs a unit normal in Q1.14 (zero when the centres coincide).
`default_nettype none
module pair_collision_tester import pct_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input wire clk,
	input wire arst_n,
	pct_pair_if.sink pair,
	pct_result_if.source result
);
	localparam int CB = COORD_BITS;
	localparam int NORM0 = FRONT_ST;
	localparam int SQRT0 = NORM0 + NORM_ST;
	localparam int DIV0 = SQRT0 + SQRT_ST;
	localparam int OUT_ST = DIV0 + DIV_ST;
	localparam int NST = OUT_ST + 1;

	logic [NST-1:0] vld_s;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !vld_s[NST-1] || result.ready;
		for (int k = NST - 2; k >= 0; k--) en[k] = !vld_s[k] || en[k+1];
	end

	logic [NST-1:0] vld_next;
	assign vld_next = {vld_s[NST-2:0], pair.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) vld_s[k] <= vld_next[k];
			end
		end
	end

	assign pair.ready = en[0];

	logic [T_W-1:0] t_f;
	logic [MAG_W-1:0] mx_f, my_f;
	pct_ctl_t ctl_f;
	logic [CB-2:0] depth_f;
	logic signed [CB-1:0] cx_f, cy_f;

	pct_front #(.CB(CB)) u_front (
		.clk(clk),
		.en(en[NORM0-1:0]),
		.a_is_circle(pair.a_is_circle),
		.a_x(pair.a_x),
		.a_y(pair.a_y),
		.a_size_x(pair.a_size_x),
		.a_size_y(pair.a_size_y),
		.b_is_circle(pair.b_is_circle),
		.b_x(pair.b_x),
		.b_y(pair.b_y),
		.b_size_x(pair.b_size_x),
		.b_size_y(pair.b_size_y),
		.t_s3(t_f),
		.mx_s3(mx_f),
		.my_s3(my_f),
		.ctl_s3(ctl_f),
		.depth_s3(depth_f),
		.cx_s3(cx_f),
		.cy_s3(cy_f)
	);

	logic [T_W-1:0] t_n;
	logic [ROOT_W-1:0] nx_n, ny_n;

	pct_norm u_norm (
		.clk(clk),
		.en(en[SQRT0-1:NORM0]),
		.t(t_f),
		.mx(mx_f),
		.my(my_f),
		.t_s2(t_n),
		.nx_s2(nx_n),
		.ny_s2(ny_n)
	);

	logic [ROOT_W-1:0] root;

	pct_sqrt u_sqrt (
		.clk(clk),
		.en(en[DIV0-1:SQRT0]),
		.t(t_n),
		.root(root)
	);

	// Scaled magnitudes wait alongside the square root.
	logic [ROOT_W-1:0] nx_s [SQRT0:DIV0-1];
	logic [ROOT_W-1:0] ny_s [SQRT0:DIV0-1];

	for (genvar k = SQRT0; k < DIV0; k++) begin : g_num
		if (k == SQRT0) begin : g_head
			always_ff @(posedge clk) begin
				if (en[k]) begin
					nx_s[k] <= nx_n;
					ny_s[k] <= ny_n;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en[k]) begin
					nx_s[k] <= nx_s[k-1];
					ny_s[k] <= ny_s[k-1];
				end
			end
		end
	end

	logic [QUOT_W-1:0] qx, qy;

	pct_div u_div_x (
		.clk(clk),
		.en(en[OUT_ST-1:DIV0]),
		.root(root),
		.num(nx_s[DIV0-1]),
		.quot(qx)
	);

	pct_div u_div_y (
		.clk(clk),
		.en(en[OUT_ST-1:DIV0]),
		.root(root),
		.num(ny_s[DIV0-1]),
		.quot(qy)
	);

	// Hit flag, box results and contact point travel with the item.
	pct_ctl_t ctl_s [NORM0:OUT_ST-1];
	logic [CB-2:0] depth_s [NORM0:OUT_ST-1];
	logic signed [CB-1:0] cx_s [NORM0:OUT_ST-1];
	logic signed [CB-1:0] cy_s [NORM0:OUT_ST-1];

	for (genvar k = NORM0; k < OUT_ST; k++) begin : g_side
		if (k == NORM0) begin : g_head
			always_ff @(posedge clk) begin
				if (en[k]) begin
					ctl_s[k] <= ctl_f;
					depth_s[k] <= depth_f;
					cx_s[k] <= cx_f;
					cy_s[k] <= cy_f;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en[k]) begin
					ctl_s[k] <= ctl_s[k-1];
					depth_s[k] <= depth_s[k-1];
					cx_s[k] <= cx_s[k-1];
					cy_s[k] <= cy_s[k-1];
				end
			end
		end
	end

	pct_ctl_t ctl_o;
	logic signed [NORM_W-1:0] qxs, qys, nx_o, ny_o;
	logic [CB-2:0] depth_o;
	logic signed [CB-1:0] cx_o, cy_o;

	always_comb begin
		ctl_o = ctl_s[OUT_ST-1];
		qxs = ($signed(qx) > NORM_ONE) ? NORM_ONE : $signed(qx);
		qys = ($signed(qy) > NORM_ONE) ? NORM_ONE : $signed(qy);
		nx_o = '0;
		ny_o = '0;
		depth_o = '0;
		cx_o = '0;
		cy_o = '0;
		if (ctl_o.hit) begin
			cx_o = cx_s[OUT_ST-1];
			cy_o = cy_s[OUT_ST-1];
			if (ctl_o.is_box) begin
				depth_o = depth_s[OUT_ST-1];
				if (ctl_o.box_on_x) nx_o = ctl_o.box_neg ? -NORM_ONE : NORM_ONE;
				else ny_o = ctl_o.box_neg ? -NORM_ONE : NORM_ONE;
			end else if (!ctl_o.vzero) begin
				nx_o = ctl_o.sgn_x ? -qxs : qxs;
				ny_o = ctl_o.sgn_y ? -qys : qys;
			end
		end
	end

	logic colliding_s31;
	logic signed [NORM_W-1:0] normal_x_s31, normal_y_s31;
	logic [CB-2:0] depth_s31;
	logic signed [CB-1:0] contact_x_s31, contact_y_s31;

	always_ff @(posedge clk) begin
		if (en[OUT_ST]) begin
			colliding_s31 <= ctl_o.hit;
			normal_x_s31 <= nx_o;
			normal_y_s31 <= ny_o;
			depth_s31 <= depth_o;
			contact_x_s31 <= cx_o;
			contact_y_s31 <= cy_o;
		end
	end

	assign result.valid = vld_s[OUT_ST];
	assign result.colliding = colliding_s31;
	assign result.normal_x = normal_x_s31;
	assign result.normal_y = normal_y_s31;
	assign result.depth = depth_s31;
	assign result.contact_x = contact_x_s31;
	assign result.contact_y = contact_y_s31;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.colliding |-> result.normal_x == '0 &&
		result.normal_y == '0 && result.depth == '0 && result.contact_x == '0 &&
		result.contact_y == '0)
		else $error("miss result carries nonzero contact data");

	a_depth_axis: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.colliding && result.depth != '0 |->
		((result.normal_x == '0) != (result.normal_y == '0)))
		else $error("box depth without a single-axis normal");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.normal_x <= NORM_ONE && result.normal_x >= -NORM_ONE &&
		result.normal_y <= NORM_ONE && result.normal_y >= -NORM_ONE)
		else $error("normal component out of range");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_s) |-> pair.ready)
		else $error("pair refused while the pipeline has a free stage");

endmodule
`default_nettype wire

// ===== hdl/pct_front.sv =====
`default_nettype none
module pct_front import pct_pkg::*; #(parameter int CB = 24) (
	input wire clk,
	input wire [FRONT_ST-1:0] en,
	input wire a_is_circle,
	input wire signed [CB-1:0] a_x,
	input wire signed [CB-1:0] a_y,
	input wire [CB-2:0] a_size_x,
	input wire [CB-2:0] a_size_y,
	input wire b_is_circle,
	input wire signed [CB-1:0] b_x,
	input wire signed [CB-1:0] b_y,
	input wire [CB-2:0] b_size_x,
	input wire [CB-2:0] b_size_y,
	output logic [T_W-1:0] t_s3,
	output logic [MAG_W-1:0] mx_s3,
	output logic [MAG_W-1:0] my_s3,
	output pct_ctl_t ctl_s3,
	output logic [CB-2:0] depth_s3,
	output logic signed [CB-1:0] cx_s3,
	output logic signed [CB-1:0] cy_s3
);
	localparam int E = CB + 3;
	localparam int M = CB + 1;

	logic signed [E-1:0] ax, ay, bx, by, aw, ah, bw, bh;
	logic signed [E-1:0] ccx, ccy, kbx, kby, kw, kh, rad;
	logic signed [E-1:0] cdx, cdy, lox, hix, loy, hiy, gx, gy;
	logic signed [E-1:0] vx, vy, dax, day, ox2, oy2, dep, csx, csy;
	logic hit_bb, on_x, neg;

	assign ax = E'(a_x);
	assign ay = E'(a_y);
	assign bx = E'(b_x);
	assign by = E'(b_y);
	assign aw = E'(a_size_x);
	assign ah = E'(a_size_y);
	assign bw = E'(b_size_x);
	assign bh = E'(b_size_y);

	// All half sizes are kept in doubled units so every comparison is exact.
	always_comb begin
		hit_bb = (ax + ax - aw < bx + bx + bw) && (ax + ax + aw > bx + bx - bw) &&
			(ay + ay - ah < by + by + bh) && (ay + ay + ah > by + by - bh);
		// A circle pair is treated as a point against a zero-sized box with the
		// summed radius.
		if (a_is_circle && b_is_circle) begin
			ccx = ax; ccy = ay; kbx = bx; kby = by; kw = '0; kh = '0; rad = aw + bw;
		end else if (!a_is_circle) begin
			ccx = bx; ccy = by; kbx = ax; kby = ay; kw = aw; kh = ah; rad = bw;
		end else begin
			ccx = ax; ccy = ay; kbx = bx; kby = by; kw = bw; kh = bh; rad = aw;
		end
		cdx = ccx + ccx;
		cdy = ccy + ccy;
		lox = kbx + kbx - kw;
		hix = kbx + kbx + kw;
		loy = kby + kby - kh;
		hiy = kby + kby + kh;
		if (cdx < lox) gx = lox - cdx;
		else if (cdx > hix) gx = cdx - hix;
		else gx = '0;
		if (cdy < loy) gy = loy - cdy;
		else if (cdy > hiy) gy = cdy - hiy;
		else gy = '0;
		vx = bx - ax;
		vy = by - ay;
		dax = (ax < bx) ? bx - ax : ax - bx;
		day = (ay < by) ? by - ay : ay - by;
		ox2 = aw + bw - (dax + dax);
		oy2 = ah + bh - (day + day);
		on_x = ox2 < oy2;
		dep = on_x ? ox2 : oy2;
		neg = on_x ? (ax < bx) : (ay < by);
		csx = ax + bx;
		csy = ay + by;
	end

	logic is_box_s1, hit_bb_s1, on_x_s1, neg_s1, sgnx_s1, sgny_s1, vzero_s1;
	logic [CB-2:0] depth_s1;
	logic signed [CB-1:0] cx_s1, cy_s1;
	logic [M-1:0] dxm_s1, dym_s1, rm_s1;
	logic [CB-1:0] vmx_s1, vmy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			is_box_s1 <= !a_is_circle && !b_is_circle;
			hit_bb_s1 <= hit_bb;
			on_x_s1 <= on_x;
			neg_s1 <= neg;
			depth_s1 <= dep[CB-1:1];
			cx_s1 <= csx[CB:1];
			cy_s1 <= csy[CB:1];
			dxm_s1 <= M'(gx);
			dym_s1 <= M'(gy);
			rm_s1 <= M'(rad + rad);
			vmx_s1 <= CB'(vx[E-1] ? -vx : vx);
			vmy_s1 <= CB'(vy[E-1] ? -vy : vy);
			sgnx_s1 <= vx[E-1];
			sgny_s1 <= vy[E-1];
			vzero_s1 <= (vx == '0) && (vy == '0);
		end
	end

	// Halve both magnitudes until each fits below 2^30.
	logic [CB-1:0] vor;
	logic [CB-1:0] mxs, mys;
	int sh;

	always_comb begin
		vor = vmx_s1 | vmy_s1;
		sh = 0;
		for (int i = MAG_W; i < CB; i++) begin
			if (vor[i]) sh = i - MAG_W + 1;
		end
		mxs = vmx_s1 >> sh;
		mys = vmy_s1 >> sh;
	end

	logic is_box_s2, hit_bb_s2, on_x_s2, neg_s2, sgnx_s2, sgny_s2, vzero_s2;
	logic [CB-2:0] depth_s2;
	logic signed [CB-1:0] cx_s2, cy_s2;
	logic [2*M-1:0] dsqx_s2, dsqy_s2, rsq_s2;
	logic [MAG_W-1:0] mx_s2, my_s2;
	logic [2*MAG_W-1:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			is_box_s2 <= is_box_s1;
			hit_bb_s2 <= hit_bb_s1;
			on_x_s2 <= on_x_s1;
			neg_s2 <= neg_s1;
			sgnx_s2 <= sgnx_s1;
			sgny_s2 <= sgny_s1;
			vzero_s2 <= vzero_s1;
			depth_s2 <= depth_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			dsqx_s2 <= dxm_s1 * dxm_s1;
			dsqy_s2 <= dym_s1 * dym_s1;
			rsq_s2 <= rm_s1 * rm_s1;
			mx_s2 <= MAG_W'(mxs);
			my_s2 <= MAG_W'(mys);
			sqx_s2 <= MAG_W'(mxs) * MAG_W'(mxs);
			sqy_s2 <= MAG_W'(mys) * MAG_W'(mys);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3 <= T_W'(sqx_s2) + T_W'(sqy_s2);
			mx_s3 <= mx_s2;
			my_s3 <= my_s2;
			ctl_s3.hit <= is_box_s2 ? hit_bb_s2 :
				(({1'b0, dsqx_s2} + {1'b0, dsqy_s2}) < {1'b0, rsq_s2});
			ctl_s3.is_box <= is_box_s2;
			ctl_s3.vzero <= vzero_s2;
			ctl_s3.sgn_x <= sgnx_s2;
			ctl_s3.sgn_y <= sgny_s2;
			ctl_s3.box_on_x <= on_x_s2;
			ctl_s3.box_neg <= neg_s2;
			depth_s3 <= depth_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/pct_norm.sv =====
`default_nettype none
module pct_norm import pct_pkg::*; (
	input wire clk,
	input wire [NORM_ST-1:0] en,
	input wire [T_W-1:0] t,
	input wire [MAG_W-1:0] mx,
	input wire [MAG_W-1:0] my,
	output logic [T_W-1:0] t_s2,
	output logic [ROOT_W-1:0] nx_s2,
	output logic [ROOT_W-1:0] ny_s2
);
	// The sum of squares is shifted by whole bit pairs until one of its top
	// two bits is set; the same count later scales the magnitudes.
	logic [T_W-1:0] t_a, t_s1, t_b;
	logic [SHIFT_W-1:0] s_a, s_s1, s_b;
	logic [MAG_W-1:0] mx_s1, my_s1;
	logic [SQ_W-1:0] nxw, nyw;

	always_comb begin
		t_a = t;
		s_a = '0;
		if (t_a[T_W-1 -: 32] == '0) begin
			t_a = t_a << 32;
			s_a = s_a + SHIFT_W'(16);
		end
		if (t_a[T_W-1 -: 16] == '0) begin
			t_a = t_a << 16;
			s_a = s_a + SHIFT_W'(8);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1 <= t_a;
			s_s1 <= s_a;
			mx_s1 <= mx;
			my_s1 <= my;
		end
	end

	always_comb begin
		t_b = t_s1;
		s_b = s_s1;
		if (t_b[T_W-1 -: 8] == '0) begin
			t_b = t_b << 8;
			s_b = s_b + SHIFT_W'(4);
		end
		if (t_b[T_W-1 -: 4] == '0) begin
			t_b = t_b << 4;
			s_b = s_b + SHIFT_W'(2);
		end
		if (t_b[T_W-1 -: 2] == '0) begin
			t_b = t_b << 2;
			s_b = s_b + SHIFT_W'(1);
		end
		nxw = SQ_W'(mx_s1) << s_b;
		nyw = SQ_W'(my_s1) << s_b;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s2 <= t_b;
			nx_s2 <= ROOT_W'(nxw);
			ny_s2 <= ROOT_W'(nyw);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/pct_sqrt.sv =====
`default_nettype none
module pct_sqrt import pct_pkg::*; (
	input wire clk,
	input wire [SQRT_ST-1:0] en,
	input wire [T_W-1:0] t,
	output logic [ROOT_W-1:0] root
);
	// Digit-by-digit square root, two result bits per stage (one in the last).
	pct_sqrt_t st_s [SQRT_ST];
	logic [T_W-1:0] tt_s [SQRT_ST];

	for (genvar k = 0; k < SQRT_ST; k++) begin : g_stage
		pct_sqrt_t st_in, st_mid, st_out;
		logic [T_W-1:0] tt_in;

		if (k == 0) begin : g_first
			assign st_in = '0;
			assign tt_in = t;
		end else begin : g_next
			assign st_in = st_s[k-1];
			assign tt_in = tt_s[k-1];
		end

		always_comb begin
			st_mid = sqrt_step(st_in, tt_in[T_W-1 -: 2]);
			if (2 * k + 1 < ROOT_W) st_out = sqrt_step(st_mid, tt_in[T_W-3 -: 2]);
			else st_out = st_mid;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				st_s[k] <= st_out;
				tt_s[k] <= tt_in << 4;
			end
		end
	end

	assign root = st_s[SQRT_ST-1].root;

endmodule
`default_nettype wire

// ===== hdl/pct_div.sv =====
`default_nettype none
module pct_div import pct_pkg::*; (
	input wire clk,
	input wire [DIV_ST-1:0] en,
	input wire [ROOT_W-1:0] root,
	input wire [ROOT_W-1:0] num,
	output logic [QUOT_W-1:0] quot
);
	// Rounded quotient num * 2^14 / root, computed as
	// floor((num * 2^15 + root) / (2 * root)): a load stage, then two quotient bits per stage.
	// The magnitude never exceeds the root, so the quotient fits in 16 bits.
	logic [DVD_W-1:0] dvd;
	logic [DREM_W-1:0] rem_s [DIV_ST];
	logic [DREM_W-1:0] dvs_s [DIV_ST];
	logic [QUOT_W-1:0] low_s [DIV_ST];
	logic [QUOT_W-1:0] q_s [DIV_ST];

	assign dvd = (DVD_W'(num) << (QUOT_W - 1)) + DVD_W'(root);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= DREM_W'(dvd[DVD_W-1:QUOT_W]);
			low_s[0] <= dvd[QUOT_W-1:0];
			dvs_s[0] <= {root, 1'b0};
			q_s[0] <= '0;
		end
	end

	for (genvar k = 1; k < DIV_ST; k++) begin : g_stage
		pct_div_t d1, d2;

		always_comb begin
			d1 = div_step(rem_s[k-1], low_s[k-1][QUOT_W-1], dvs_s[k-1]);
			d2 = div_step(d1.rem, low_s[k-1][QUOT_W-2], dvs_s[k-1]);
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= d2.rem;
				low_s[k] <= low_s[k-1] << 2;
				dvs_s[k] <= dvs_s[k-1];
				q_s[k] <= {q_s[k-1][QUOT_W-3:0], d1.q, d2.q};
			end
		end
	end

	assign quot = q_s[DIV_ST-1];

endmodule
`default_nettype wire
